// File: design/cda_pkg.sv
// Shared types, constants and the control store of the calendar date adder.
// No dependencies; every other file uses it through scoped names.
package cda_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W   = 2;
    localparam int AMT_W   = 16;
    localparam int SYEAR_W = 16;
    localparam int SMON_W  = 8;
    localparam int SDAY_W  = 16;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;

    // Working day/month count and month-division quotient widths
    localparam int CNT_W = 17;
    localparam int MQ_W  = 13;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_YEARS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MONTHS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DAYS   = 2'd3;

    // Calendar constants
    localparam int MONTHS_PER_YEAR = 12;
    localparam int LEAP_STEP       = 4;
    localparam int CENTURY         = 100;

    // floor(x / 12) as (x * MDIV_RECIP) >> MDIV_SHIFT, exact for x below 2^17
    localparam logic [CNT_W-1:0] MDIV_RECIP = 17'd87382;
    localparam int               MDIV_SHIFT = 20;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_LATCH    = 4'd1;
    localparam logic [OP_W-1:0] OP_SETLOAD  = 4'd2;
    localparam logic [OP_W-1:0] OP_MDIV     = 4'd3;
    localparam logic [OP_W-1:0] OP_MAPPLY   = 4'd4;
    localparam logic [OP_W-1:0] OP_DLD_SET  = 4'd5;
    localparam logic [OP_W-1:0] OP_MLOAD    = 4'd6;
    localparam logic [OP_W-1:0] OP_DLD_ADD  = 4'd7;
    localparam logic [OP_W-1:0] OP_LEAP0    = 4'd8;
    localparam logic [OP_W-1:0] OP_LEAP1    = 4'd9;
    localparam logic [OP_W-1:0] OP_DSTEP    = 4'd10;
    localparam logic [OP_W-1:0] OP_PUSH     = 4'd11;
    localparam logic [OP_W-1:0] OP_YADD     = 4'd12;

    // Sequencer branch conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
    localparam logic [COND_W-1:0] C_JUMP     = 3'd1;
    localparam logic [COND_W-1:0] C_WAIT     = 3'd2;
    localparam logic [COND_W-1:0] C_DISPATCH = 3'd3;
    localparam logic [COND_W-1:0] C_IFNSET   = 3'd4;
    localparam logic [COND_W-1:0] C_DAY      = 3'd5;
    localparam logic [COND_W-1:0] C_PUSH     = 3'd6;

    // Control store addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] A_WAIT    = 4'd0;
    localparam logic [PC_W-1:0] A_DISP    = 4'd1;
    localparam logic [PC_W-1:0] A_SET0    = 4'd2;
    localparam logic [PC_W-1:0] A_MDIV    = 4'd3;
    localparam logic [PC_W-1:0] A_MAPPLY  = 4'd4;
    localparam logic [PC_W-1:0] A_SETDAY  = 4'd5;
    localparam logic [PC_W-1:0] A_MADD    = 4'd6;
    localparam logic [PC_W-1:0] A_DADD    = 4'd7;
    localparam logic [PC_W-1:0] A_LEAP0   = 4'd8;
    localparam logic [PC_W-1:0] A_LEAP1   = 4'd9;
    localparam logic [PC_W-1:0] A_DLOOP   = 4'd10;
    localparam logic [PC_W-1:0] A_DONE    = 4'd11;
    localparam logic [PC_W-1:0] A_YADD    = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   tgt;
    } uword_t;

    // Datapath control, sequencer to datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
    } ctrl_t;

    // Datapath status, datapath to sequencer
    typedef struct packed {
        logic             in_valid;
        logic             out_free;
        logic [CMD_W-1:0] cmd;
        logic             day_fits;
        logic             month_wrap;
    } stat_t;

    // Microprogram
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            A_WAIT:   w = '{OP_LATCH,   C_WAIT,     A_WAIT};
            A_DISP:   w = '{OP_NOP,     C_DISPATCH, A_WAIT};
            A_SET0:   w = '{OP_SETLOAD, C_NEXT,     A_WAIT};
            A_MDIV:   w = '{OP_MDIV,    C_NEXT,     A_WAIT};
            A_MAPPLY: w = '{OP_MAPPLY,  C_IFNSET,   A_DONE};
            A_SETDAY: w = '{OP_DLD_SET, C_JUMP,     A_LEAP0};
            A_MADD:   w = '{OP_MLOAD,   C_JUMP,     A_MDIV};
            A_DADD:   w = '{OP_DLD_ADD, C_NEXT,     A_WAIT};
            A_LEAP0:  w = '{OP_LEAP0,   C_NEXT,     A_WAIT};
            A_LEAP1:  w = '{OP_LEAP1,   C_NEXT,     A_WAIT};
            A_DLOOP:  w = '{OP_DSTEP,   C_DAY,      A_LEAP0};
            A_DONE:   w = '{OP_PUSH,    C_PUSH,     A_WAIT};
            A_YADD:   w = '{OP_YADD,    C_JUMP,     A_DONE};
            default:  w = '{OP_NOP,     C_JUMP,     A_WAIT};
        endcase
        return w;
    endfunction

    // Entry point of each command's routine
    function automatic logic [PC_W-1:0] dispatch(input logic [CMD_W-1:0] cmd);
        logic [PC_W-1:0] a;
        unique case (cmd)
            CMD_SET:    a = A_SET0;
            CMD_YEARS:  a = A_YADD;
            CMD_MONTHS: a = A_MADD;
            default:    a = A_DADD;
        endcase
        return a;
    endfunction

    // Month length, month 1..12
    function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: design/cda_in_if.sv
// Command channel: valid/ready handshake with the command and its operands.
// Depends on cda_pkg for field widths.
interface cda_in_if;
    logic                          valid;
    logic                          ready;
    logic [cda_pkg::CMD_W-1:0]     cmd;
    logic [cda_pkg::AMT_W-1:0]     amount;
    logic [cda_pkg::SYEAR_W-1:0]   set_year;
    logic [cda_pkg::SMON_W-1:0]    set_month;
    logic [cda_pkg::SDAY_W-1:0]    set_day;

    modport source (output valid, cmd, amount, set_year, set_month, set_day,
                    input ready);
    modport sink   (input valid, cmd, amount, set_year, set_month, set_day,
                    output ready);
endinterface

// File: design/cda_out_if.sv
// Result channel: valid/ready handshake carrying the current date.
// Depends on cda_pkg for field widths.
interface cda_out_if #(parameter int YEAR_WIDTH = 16);
    logic                        valid;
    logic                        ready;
    logic [YEAR_WIDTH-1:0]       year;
    logic [cda_pkg::MON_W-1:0]   month;
    logic [cda_pkg::DAY_W-1:0]   day;

    modport source (output valid, year, month, day, input ready);
    modport sink   (input valid, year, month, day, output ready);
endinterface

// File: design/calendar_date_adder_top.sv
// Calendar date adder, top level. Depends on cda_pkg, cda_in_if, cda_out_if,
// cda_useq and cda_dpath.
// One command at a time; the next transfer can be taken the cycle after the result is
// loaded into the output register. Reset (async, active low) gives 1/1/1.
module calendar_date_adder_top #(
    parameter int YEAR_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    cda_in_if.sink     item,
    cda_out_if.source  result
);

    // The sequencer steps through a 13-word microprogram; each word names one
    // datapath operation and a branch. The day walk is a single word that loops
    // on itself, subtracting one month length per cycle, and jumps back into the
    // two-step leap evaluation whenever December rolls over into a new year.
    cda_pkg::ctrl_t ctrl;
    cda_pkg::stat_t stat;

    cda_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Datapath holds the current date, the operand latch and the output register,
    // so a finished result can wait for its transfer while the next command loads.
    cda_dpath #(
        .YEAR_WIDTH (YEAR_WIDTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .stat   (stat),
        .item   (item),
        .result (result)
    );

endmodule

// File: design/cda_useq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on cda_pkg for the microprogram, control and status types.
module cda_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  cda_pkg::stat_t  stat,
    output cda_pkg::ctrl_t  ctrl
);

    logic [cda_pkg::PC_W-1:0] pc_reg;
    logic [cda_pkg::PC_W-1:0] pc_next;
    logic [cda_pkg::PC_W-1:0] pc_inc;
    cda_pkg::uword_t          uw;

    assign uw      = cda_pkg::ucode_rom(pc_reg);
    assign ctrl.op = uw.op;
    assign pc_inc  = pc_reg + cda_pkg::PC_W'(1);

    always_comb
    begin
        unique case (uw.cond)
            cda_pkg::C_NEXT:     pc_next = pc_inc;
            cda_pkg::C_JUMP:     pc_next = uw.tgt;
            cda_pkg::C_WAIT:     pc_next = stat.in_valid ? pc_inc : pc_reg;
            cda_pkg::C_DISPATCH: pc_next = cda_pkg::dispatch(stat.cmd);
            cda_pkg::C_IFNSET:   pc_next = (stat.cmd != cda_pkg::CMD_SET) ? uw.tgt : pc_inc;
            cda_pkg::C_DAY:
            begin
                // fall through when the day fits, recheck leap after a year wrap
                if (stat.day_fits)
                    pc_next = pc_inc;
                else if (stat.month_wrap)
                    pc_next = uw.tgt;
                else
                    pc_next = pc_reg;
            end
            cda_pkg::C_PUSH:     pc_next = stat.out_free ? uw.tgt : pc_reg;
            default:             pc_next = cda_pkg::A_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= cda_pkg::A_WAIT;
        else
            pc_reg <= pc_next;
    end

endmodule

// File: design/cda_dpath.sv
// Datapath: date registers, operand latch, divide-by-12 and leap units,
// month walk and the result register. Depends on cda_pkg and both interfaces.
module cda_dpath #(
    parameter int YEAR_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cda_pkg::ctrl_t  ctrl,
    output cda_pkg::stat_t  stat,
    cda_in_if.sink          item,
    cda_out_if.source       result
);

    localparam int YW   = YEAR_WIDTH;
    localparam int SW   = ((YW > cda_pkg::AMT_W) ? YW : cda_pkg::AMT_W) + 1;
    localparam int HQ_W = YW - 6;
    localparam int HS   = YW + 7;
    localparam int KW   = YW + 1;
    localparam int PW   = 2 * YW + 1;
    localparam longint unsigned HK_L =
        ((64'd1 << HS) + 64'd99) / 64'(cda_pkg::CENTURY);
    localparam logic [KW-1:0] HK   = KW'(HK_L);
    localparam logic [YW-1:0] YMAX = '1;

    localparam int MPW = 2 * cda_pkg::CNT_W;

    logic [cda_pkg::CMD_W-1:0]   cmd_reg;
    logic [cda_pkg::AMT_W-1:0]   amt_reg;
    logic [cda_pkg::SYEAR_W-1:0] syear_reg;
    logic [cda_pkg::SMON_W-1:0]  smon_reg;
    logic [cda_pkg::SDAY_W-1:0]  sday_reg;

    logic [YW-1:0]               yr_reg,  yr_next;
    logic [cda_pkg::MON_W-1:0]   mon_reg, mon_next;
    logic [cda_pkg::DAY_W-1:0]   day_reg, day_next;
    logic [cda_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [cda_pkg::MQ_W-1:0]    mq_reg;
    logic [HQ_W-1:0]             hq_reg;
    logic                        leap_reg;

    logic                        ovalid_reg;
    logic [YW-1:0]               oyear_reg;
    logic [cda_pkg::MON_W-1:0]   omon_reg;
    logic [cda_pkg::DAY_W-1:0]   oday_reg;

    logic                        latch;
    logic                        push;
    logic                        out_free;
    logic [MPW-1:0]              mprod;
    logic [cda_pkg::CNT_W-1:0]   mrem;
    logic [PW-1:0]               hprod;
    logic [YW-1:0]               r100;
    logic [cda_pkg::DAY_W-1:0]   len;
    logic                        fits;
    logic                        wrap;

    function automatic logic [YW-1:0] sat_add(input logic [YW-1:0] a,
                                              input logic [cda_pkg::AMT_W-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        return (s > SW'(YMAX)) ? YMAX : YW'(s);
    endfunction

    assign out_free   = !ovalid_reg || result.ready;
    assign latch      = (ctrl.op == cda_pkg::OP_LATCH) && item.valid;
    assign push       = (ctrl.op == cda_pkg::OP_PUSH) && out_free;
    assign item.ready = (ctrl.op == cda_pkg::OP_LATCH);

    assign result.valid = ovalid_reg;
    assign result.year  = oyear_reg;
    assign result.month = omon_reg;
    assign result.day   = oday_reg;

    // divide the month count by 12, take the remainder from the registered quotient
    assign mprod = MPW'(cnt_reg) * MPW'(cda_pkg::MDIV_RECIP);
    assign mrem  = cnt_reg - cda_pkg::CNT_W'(mq_reg) * cda_pkg::CNT_W'(cda_pkg::MONTHS_PER_YEAR);

    // year / 100 by reciprocal, remainder from the registered quotient
    assign hprod = PW'(yr_reg) * PW'(HK);
    assign r100  = yr_reg - YW'(hq_reg) * YW'(cda_pkg::CENTURY);

    assign len  = cda_pkg::days_in(mon_reg, leap_reg);
    assign fits = (cnt_reg <= cda_pkg::CNT_W'(len));
    assign wrap = (mon_reg >= cda_pkg::MON_W'(cda_pkg::MONTHS_PER_YEAR));

    assign stat.in_valid   = item.valid;
    assign stat.out_free   = out_free;
    assign stat.cmd        = cmd_reg;
    assign stat.day_fits   = fits;
    assign stat.month_wrap = wrap;

    always_comb
    begin
        yr_next  = yr_reg;
        mon_next = mon_reg;
        day_next = day_reg;
        cnt_next = cnt_reg;
        case (ctrl.op)
            cda_pkg::OP_SETLOAD:
            begin
                yr_next  = sat_add('0, syear_reg);
                cnt_next = (smon_reg == '0) ? '0
                         : cda_pkg::CNT_W'(smon_reg) - cda_pkg::CNT_W'(1);
            end
            cda_pkg::OP_MAPPLY:
            begin
                yr_next  = sat_add(yr_reg, cda_pkg::AMT_W'(mq_reg));
                mon_next = mrem[cda_pkg::MON_W-1:0] + cda_pkg::MON_W'(1);
            end
            cda_pkg::OP_DLD_SET:
                cnt_next = (sday_reg == '0) ? cda_pkg::CNT_W'(1) : cda_pkg::CNT_W'(sday_reg);
            cda_pkg::OP_MLOAD:
                cnt_next = cda_pkg::CNT_W'(mon_reg) + cda_pkg::CNT_W'(amt_reg)
                         - cda_pkg::CNT_W'(1);
            cda_pkg::OP_DLD_ADD:
                cnt_next = cda_pkg::CNT_W'(day_reg) + cda_pkg::CNT_W'(amt_reg);
            cda_pkg::OP_YADD:
                yr_next = sat_add(yr_reg, amt_reg);
            cda_pkg::OP_DSTEP:
            begin
                if (fits)
                begin
                    day_next = cnt_reg[cda_pkg::DAY_W-1:0];
                end
                else
                begin
                    // advance one month, carry into the year at December
                    cnt_next = cnt_reg - cda_pkg::CNT_W'(len);
                    if (wrap)
                    begin
                        mon_next = cda_pkg::MON_W'(1);
                        yr_next  = sat_add(yr_reg, cda_pkg::AMT_W'(1));
                    end
                    else
                    begin
                        mon_next = mon_reg + cda_pkg::MON_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yr_reg     <= YW'(1);
            mon_reg    <= cda_pkg::MON_W'(1);
            day_reg    <= cda_pkg::DAY_W'(1);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            yr_reg  <= yr_next;
            mon_reg <= mon_next;
            day_reg <= day_next;
            if (push)
                ovalid_reg <= 1'b1;
            else if (result.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (latch)
        begin
            cmd_reg   <= item.cmd;
            amt_reg   <= item.amount;
            syear_reg <= item.set_year;
            smon_reg  <= item.set_month;
            sday_reg  <= item.set_day;
        end
        if (ctrl.op == cda_pkg::OP_MDIV)
            mq_reg <= cda_pkg::MQ_W'(mprod >> cda_pkg::MDIV_SHIFT);
        if (ctrl.op == cda_pkg::OP_LEAP0)
            hq_reg <= HQ_W'(hprod >> HS);
        if (ctrl.op == cda_pkg::OP_LEAP1)
            leap_reg <= (yr_reg[1:0] == 2'd0) && ((r100 != '0) || (hq_reg[1:0] == 2'd0));
        if (push)
        begin
            oyear_reg <= yr_reg;
            omon_reg  <= mon_reg;
            oday_reg  <= day_reg;
        end
    end

endmodule

// File: dv/calendar_date_adder_top_tb.sv
// Testbench for calendar_date_adder_top: drives date commands over the command channel
// and checks every returned date against a date tracker kept alongside the block.
// Depends on cda_pkg, cda_in_if, cda_out_if and the block itself.
module calendar_date_adder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          YEAR_W   = 16;
    localparam int unsigned YEAR_TOP = (1 << YEAR_W) - 1;
    localparam int          MAX_REPORTS = 10;

    // One command as it crosses the command channel
    typedef struct packed {
        logic [cda_pkg::CMD_W-1:0]   cmd;
        logic [cda_pkg::AMT_W-1:0]   amount;
        logic [cda_pkg::SYEAR_W-1:0] set_year;
        logic [cda_pkg::SMON_W-1:0]  set_month;
        logic [cda_pkg::SDAY_W-1:0]  set_day;
    } date_cmd_t;

    // One date as it crosses the result channel
    typedef struct packed {
        logic [YEAR_W-1:0]         year;
        logic [cda_pkg::MON_W-1:0] month;
        logic [cda_pkg::DAY_W-1:0] day;
    } date_t;

    // Tracks the calendar date the block should hold and queues the date expected
    // after each accepted command.
    class date_tracker;
        int unsigned cur_y;
        int unsigned cur_m;
        int unsigned cur_d;
        date_t       dates_due[$];
        int          failures;

        function new();
            cur_y    = 1;
            cur_m    = 1;
            cur_d    = 1;
            failures = 0;
        endfunction

        function bit leap_year(int unsigned y);
            if (y % 4 != 0)
                return 1'b0;
            if (y % 100 != 0)
                return 1'b1;
            return (y % 400 == 0);
        endfunction

        function int unsigned month_days(int unsigned m, int unsigned y);
            case (m)
                2:             return leap_year(y) ? 29 : 28;
                4, 6, 9, 11:   return 30;
                default:       return 31;
            endcase
        endfunction

        function void add_years(longint unsigned inc);
            longint unsigned sum;
            sum   = longint'(cur_y) + inc;
            cur_y = (sum > YEAR_TOP) ? YEAR_TOP : int'(sum);
        endfunction

        // mc counts months from 1 and may run past 12
        function void carry_month(int unsigned mc);
            if (mc == 0)
                mc = 1;
            add_years(64'((mc - 1) / 12));
            cur_m = (mc - 1) % 12 + 1;
        endfunction

        // dc counts days from 1 and may run past the current month
        function void walk_days(int unsigned dc);
            int unsigned len;
            if (dc == 0)
                dc = 1;
            len = month_days(cur_m, cur_y);
            while (dc > len) begin
                dc -= len;
                if (cur_m >= 12) begin
                    cur_m = 1;
                    add_years(1);
                end
                else begin
                    cur_m++;
                end
                len = month_days(cur_m, cur_y);
            end
            cur_d = dc;
        endfunction

        function void note_command(date_cmd_t c);
            date_t due;
            case (c.cmd)
                cda_pkg::CMD_SET: begin
                    cur_y = 32'(c.set_year);
                    carry_month(32'(c.set_month));
                    walk_days(32'(c.set_day));
                end
                cda_pkg::CMD_YEARS:  add_years(64'(c.amount));
                cda_pkg::CMD_MONTHS: carry_month(cur_m + 32'(c.amount));
                default:             walk_days(cur_d + 32'(c.amount));
            endcase
            due.year  = cur_y[YEAR_W-1:0];
            due.month = cur_m[cda_pkg::MON_W-1:0];
            due.day   = cur_d[cda_pkg::DAY_W-1:0];
            dates_due.push_back(due);
        endfunction

        function void check_date(date_t got);
            date_t due;
            if (dates_due.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected date %0d/%0d/%0d with nothing outstanding",
                             got.year, got.month, got.day);
                return;
            end
            due = dates_due.pop_front();
            if (got.year !== due.year || got.month !== due.month || got.day !== due.day) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("date mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             due.year, due.month, due.day, got.year, got.month, got.day);
            end
        endfunction

        function int outstanding();
            return dates_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cda_in_if                          item_if();
    cda_out_if #(.YEAR_WIDTH(YEAR_W))  result_if();

    calendar_date_adder_top #(.YEAR_WIDTH(YEAR_W)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    date_tracker tracker = new();

    // Idle odds in percent, changed per phase
    int sender_idle_pct;
    int rcv_stall_pct;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: decide ready once per cycle at the falling edge
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            result_if.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // Check every result transfer against the oldest outstanding date
    always @(posedge clk) begin
        if (rst_n && result_if.valid && result_if.ready)
            tracker.check_date('{result_if.year, result_if.month, result_if.day});
    end

    // Hold a command until it transfers; valid stays high when the next one follows
    // without a gap, so it is only ever lowered at the start of an idle cycle.
    task automatic send_cmd(date_cmd_t c);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge clk);
            item_if.valid <= 1'b0;
        end
        @(negedge clk);
        item_if.valid     <= 1'b1;
        item_if.cmd       <= c.cmd;
        item_if.amount    <= c.amount;
        item_if.set_year  <= c.set_year;
        item_if.set_month <= c.set_month;
        item_if.set_day   <= c.set_day;
        do
            @(posedge clk);
        while (!item_if.ready);
        tracker.note_command(c);
    endtask

    task automatic send_fields(logic [cda_pkg::CMD_W-1:0] cmd,
                               logic [cda_pkg::AMT_W-1:0] amount,
                               logic [cda_pkg::SYEAR_W-1:0] sy,
                               logic [cda_pkg::SMON_W-1:0] sm,
                               logic [cda_pkg::SDAY_W-1:0] sd);
        send_cmd('{cmd, amount, sy, sm, sd});
    endtask

    // Random command: mostly short walks that move across month and year
    // boundaries, with occasional full-range amounts and long day loads.
    task automatic send_random();
        date_cmd_t c;
        int unsigned pick;
        c.amount    = 16'($urandom);
        c.set_year  = 16'($urandom);
        c.set_month = 8'($urandom);
        c.set_day   = 16'($urandom);
        pick        = $urandom_range(0, 99);
        if (pick < 20) begin
            c.cmd = cda_pkg::CMD_SET;
            if ($urandom_range(0, 9) < 3) begin
                case ($urandom_range(0, 4))
                    0:       c.set_year = 16'd1900;
                    1:       c.set_year = 16'd2000;
                    2:       c.set_year = 16'd2100;
                    3:       c.set_year = 16'd2400;
                    default: c.set_year = 16'(YEAR_TOP - $urandom_range(0, 3));
                endcase
            end
            if ($urandom_range(0, 3) != 0)
                c.set_month = 8'($urandom_range(0, 13));
            if ($urandom_range(0, 9) < 7)
                c.set_day = 16'($urandom_range(0, 40));
        end
        else if (pick < 35) begin
            c.cmd = cda_pkg::CMD_YEARS;
            if ($urandom_range(0, 9) != 0)
                c.amount = 16'($urandom_range(0, 400));
        end
        else if (pick < 60) begin
            c.cmd = cda_pkg::CMD_MONTHS;
            if ($urandom_range(0, 7) != 0)
                c.amount = 16'($urandom_range(0, 30));
        end
        else begin
            c.cmd = cda_pkg::CMD_DAYS;
            case ($urandom_range(0, 9))
                0:       c.amount = 16'($urandom_range(0, 1500));
                1:       ;
                default: c.amount = 16'($urandom_range(0, 62));
            endcase
        end
        send_cmd(c);
    endtask

    initial begin
        int phase_idle[4];
        int phase_stall[4];
        phase_idle  = '{0, 57, 0, 23};
        phase_stall = '{0, 0, 57, 23};
        sender_idle_pct   = 0;
        rcv_stall_pct     = 0;
        rst_n             = 1'b0;
        item_if.valid     = 1'b0;
        item_if.cmd       = cda_pkg::CMD_SET;
        item_if.amount    = '0;
        item_if.set_year  = '0;
        item_if.set_month = '0;
        item_if.set_day   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run without idling
        send_fields(cda_pkg::CMD_DAYS,   16'd0, 16'd0, 8'd0, 16'd0);  // reset date
        send_fields(cda_pkg::CMD_SET, 16'hFFFF, 16'd0, 8'd2, 16'd29); // year zero is leap
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'd1900, 8'd2, 16'd29); // century, not leap
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'd2000, 8'd2, 16'd29); // 400-year leap
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'd2100, 8'd0, 16'd0);  // month and day zero
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'd2024, 8'd1, 16'd31);
        send_fields(cda_pkg::CMD_MONTHS, 16'd1, 16'd0, 8'd0, 16'd0);  // 31 February kept
        send_fields(cda_pkg::CMD_DAYS,   16'd0, 16'd0, 8'd0, 16'd0);  // and normalized here
        send_fields(cda_pkg::CMD_YEARS,  16'd1, 16'd0, 8'd0, 16'd0);
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'd2023, 8'd12, 16'd31);
        send_fields(cda_pkg::CMD_DAYS,   16'd1, 16'd0, 8'd0, 16'd0);  // year rollover
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'd100, 8'd255, 16'hFFFF); // long carry chain
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'hFFFF, 8'd12, 16'd31);
        send_fields(cda_pkg::CMD_DAYS,   16'd1, 16'd0, 8'd0, 16'd0);  // month wraps, year pinned
        send_fields(cda_pkg::CMD_YEARS,  16'hFFFF, 16'd0, 8'd0, 16'd0);
        send_fields(cda_pkg::CMD_SET, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF);
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'd1, 8'd1, 16'd1);
        send_fields(cda_pkg::CMD_MONTHS, 16'hFFFF, 16'd0, 8'd0, 16'd0);
        send_fields(cda_pkg::CMD_YEARS,  16'hFFFF, 16'd0, 8'd0, 16'd0); // saturate the year
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'd2000, 8'd1, 16'd1);
        send_fields(cda_pkg::CMD_DAYS,   16'hFFFF, 16'd0, 8'd0, 16'd0); // longest day walk
        send_fields(cda_pkg::CMD_SET, 16'd0, 16'd0, 8'd12, 16'd1);
        send_fields(cda_pkg::CMD_MONTHS, 16'd12, 16'd0, 8'd0, 16'd0);
        send_fields(cda_pkg::CMD_DAYS,   16'd0, 16'd0, 8'd0, 16'd0);

        // Random part, one phase per idling pattern
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = phase_idle[p];
            rcv_stall_pct   = phase_stall[p];
            repeat (62) send_random();
        end
        @(negedge clk);
        item_if.valid <= 1'b0;

        // Drain, then keep checking for any stray result before the verdict
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (tracker.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
